FILE: sv/dle_pkg.sv
package dle_pkg;

    localparam int LABEL_DEPTH = 63;
    localparam int LEN_W       = $clog2(LABEL_DEPTH + 1);
    localparam int ADDR_W      = LEN_W;
    localparam int BYTE_W      = 8;
    localparam int ERR_W       = 2;

    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_LABEL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_OVF,
        S_LEN,
        S_DATA,
        S_MARK
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_length;
        logic              run_last;
        logic              name_done;
        logic [ERR_W-1:0]  error;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

FILE: sv/dns_label_encoder.sv
// A plain character is stored while the label buffer has room; a '.' or the end
// of a name starts a flush: S_FLUSH, then S_LEN, S_OVF or S_MARK registers the
// first result. Throughput: while the output is free, a flush gives one result
// per cycle (length byte, then a byte per buffer read); input waits until the flush
// is handed out. Reset clears the controller and out_valid; the buffer needs none.
module dns_label_encoder
    import dle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_char,
    input  logic              name_end,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              is_length,
    output logic              run_last,
    output logic              name_done,
    output logic [ERR_W-1:0]  error
);

    logic              slot_free;
    logic              emit;
    result_t           res;
    ram_req_t          ram_req;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_valid_reg;
    result_t           out_res_reg;

    assign slot_free = !out_valid_reg || out_ready;

    dle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .name_end  (name_end),
        .slot_free (slot_free),
        .emit      (emit),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    dle_ram #(
        .DEPTH  (LABEL_DEPTH),
        .WIDTH  (BYTE_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_res_reg.out_byte;
    assign is_length = out_res_reg.is_length;
    assign run_last  = out_res_reg.run_last;
    assign name_done = out_res_reg.name_done;
    assign error     = out_res_reg.error;

endmodule

FILE: sv/dle_ram.sv
module dle_ram #(
    parameter int DEPTH  = 63,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/dle_ctrl.sv
module dle_ctrl
    import dle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_char,
    input  logic              name_end,
    input  logic              slot_free,
    output logic              emit,
    output result_t           res,
    output ram_req_t          ram_req,
    input  logic [BYTE_W-1:0] ram_rdata
);

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic              seen_reg, seen_next;
    logic              end_reg, end_next;

    logic is_drop;
    logic is_dot;
    logic is_chr;
    logic has_room;
    logic data_last;

    assign is_drop   = name_end && (in_char == CH_NEWLINE);
    assign is_dot    = !is_drop && (in_char == CH_DOT);
    assign is_chr    = !is_drop && !is_dot;
    assign has_room  = len_reg < LEN_W'(LABEL_DEPTH);
    assign data_last = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (is_dot || name_end))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (ovf_reg)
                begin
                    state_next = S_OVF;
                end
                else if (len_reg != '0)
                begin
                    state_next = S_LEN;
                end
                else if (end_reg)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OVF:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LEN:
            begin
                if (slot_free)
                begin
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                if (slot_free && data_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MARK:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        emit      = 1'b0;
        res       = '0;
        ram_req   = '0;
        len_next  = len_reg;
        idx_next  = idx_reg;
        ovf_next  = ovf_reg;
        seen_next = seen_reg;
        end_next  = end_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    end_next = name_end;
                    if (is_chr && has_room)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = ADDR_W'(len_reg);
                        ram_req.wdata = in_char;
                        len_next      = len_reg + LEN_W'(1);
                    end
                    else if (is_chr)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_OVF:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    res.error     = ERR_TOO_LONG;
                    res.run_last  = 1'b1;
                    res.name_done = end_reg;
                    len_next      = '0;
                    ovf_next      = 1'b0;
                    seen_next     = !end_reg;
                end
            end
            S_LEN:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    res.out_byte  = BYTE_W'(len_reg);
                    res.is_length = 1'b1;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = '0;
                    idx_next      = '0;
                end
            end
            S_DATA:
            begin
                if (slot_free)
                begin
                    emit         = 1'b1;
                    res.out_byte = ram_rdata;
                    if (data_last)
                    begin
                        res.run_last  = 1'b1;
                        res.name_done = end_reg;
                        len_next      = '0;
                        seen_next     = !end_reg;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = idx_reg + ADDR_W'(1);
                        idx_next      = idx_reg + ADDR_W'(1);
                    end
                end
            end
            S_MARK:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    res.error     = seen_reg ? ERR_NONE : ERR_NO_LABEL;
                    res.run_last  = 1'b1;
                    res.name_done = 1'b1;
                    seen_next     = 1'b0;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            seen_reg  <= seen_next;
            end_reg   <= end_next;
        end
    end

endmodule

FILE: sv/dle_checker.sv
module dle_checker
    import dle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              is_length,
    input logic              run_last,
    input logic              name_done,
    input logic [ERR_W-1:0]  error
);

    // A result that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(error))
    else $error("stalled result changed");

    // A length byte always has label characters after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_length |-> !run_last && error == ERR_NONE && out_byte != '0)
    else $error("length byte marked last or flagged");

    // The end of a name is always the last result of its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && name_done |-> run_last)
    else $error("name end without run end");

    // An error result stands alone, in place of a label.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error != ERR_NONE |-> out_byte == '0 && !is_length && run_last)
    else $error("malformed error result");

endmodule

bind dns_label_encoder dle_checker u_dle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_length (is_length),
    .run_last  (run_last),
    .name_done (name_done),
    .error     (error)
);

FILE: test/dns_label_encoder_test.sv
module dns_label_encoder_test
    import dle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 210;
    localparam int CALM_AFTER   = 180;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int DIR_ROWS     = 20;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              fin;
        logic              typed;
        result_t           want;
    } stim_row_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] in_char   = '0;
    logic              name_end  = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              is_length;
    logic              run_last;
    logic              name_done;
    logic [ERR_W-1:0]  error;

    logic [BYTE_W-1:0] lbl_buf [LABEL_DEPTH];
    logic [LEN_W-1:0]  lbl_len  = '0;
    logic              lbl_over = 1'b0;
    logic              lbl_seen = 1'b0;

    result_t step_bytes[$];
    result_t wire_bytes_due[$];

    int   items_sent = 0;
    int   mismatches = 0;
    int   cycles     = 0;
    int   stall_left = 0;
    logic long_hold  = 1'b0;
    logic calm;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{CH_NEWLINE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NO_LABEL}},
        '{CH_DOT,     1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NO_LABEL}},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{8'h61,      1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_NEWLINE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE}},
        '{8'h00,      1'b0, 1'b0, '0},
        '{8'hFF,      1'b0, 1'b0, '0},
        '{CH_NEWLINE, 1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{8'h7A,      1'b1, 1'b0, '0},
        '{8'h7F,      1'b0, 1'b0, '0},
        '{8'h80,      1'b0, 1'b0, '0},
        '{CH_DOT,     1'b1, 1'b0, '0},
        '{8'h71,      1'b1, 1'b0, '0},
        '{8'h55,      1'b0, 1'b0, '0},
        '{8'hAA,      1'b0, 1'b0, '0},
        '{CH_NEWLINE, 1'b1, 1'b0, '0}
    };

    assign calm = (items_sent >= CALM_AFTER);

    dns_label_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .name_end  (name_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .is_length (is_length),
        .run_last  (run_last),
        .name_done (name_done),
        .error     (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void emit(input logic [BYTE_W-1:0] b, input logic isl,
                                 input logic [ERR_W-1:0] err);
        result_t r;
        r = '0;
        r.out_byte  = b;
        r.is_length = isl;
        r.error     = err;
        step_bytes.push_back(r);
    endfunction

    function automatic void flush_pending();
        if (lbl_over)
        begin
            emit(8'h00, 1'b0, ERR_TOO_LONG);
            lbl_seen = 1'b1;
        end
        else if (lbl_len != 0)
        begin
            emit(BYTE_W'(lbl_len), 1'b1, ERR_NONE);
            for (int i = 0; i < int'(lbl_len); i++)
                emit(lbl_buf[i], 1'b0, ERR_NONE);
            lbl_seen = 1'b1;
        end
        lbl_len  = '0;
        lbl_over = 1'b0;
    endfunction

    function automatic void encode_char(input logic [BYTE_W-1:0] c, input logic fin);
        result_t r;
        step_bytes.delete();
        if (fin && c == CH_NEWLINE)
        begin
        end
        else if (c == CH_DOT)
            flush_pending();
        else if (lbl_len < LABEL_DEPTH)
        begin
            lbl_buf[lbl_len] = c;
            lbl_len = lbl_len + 1'b1;
        end
        else
            lbl_over = 1'b1;

        if (fin)
        begin
            flush_pending();
            if (step_bytes.size() == 0)
                emit(8'h00, 1'b0, lbl_seen ? ERR_NONE : ERR_NO_LABEL);
            r = step_bytes.pop_back();
            r.name_done = 1'b1;
            step_bytes.push_back(r);
            lbl_seen = 1'b0;
        end

        if (step_bytes.size() != 0)
        begin
            r = step_bytes.pop_back();
            r.run_last = 1'b1;
            step_bytes.push_back(r);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_label_char();
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 3) == 0)
        begin
            c = BYTE_W'($urandom_range(0, 255));
            if (c == CH_DOT)
                c = 8'h5F;
        end
        else
            c = 8'h61 + BYTE_W'($urandom_range(0, 25));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input logic [BYTE_W-1:0] c, input logic fin,
                             input logic typed, input result_t want);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        name_end <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        encode_char(c, fin);
        if (typed)
            wire_bytes_due.push_back(want);
        else
            foreach (step_bytes[i])
                wire_bytes_due.push_back(step_bytes[i]);
        items_sent++;
    endtask

    // A forced length makes the first label exactly that long.
    task automatic send_name(input int forced_len);
        logic [BYTE_W-1:0] chars[$];
        int n_lbl;
        int len;
        int tail;
        if (forced_len == 0 && $urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10))
            begin
                if ($urandom_range(0, 2) == 0)
                    chars.push_back(CH_DOT);
                else
                    chars.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
        else
        begin
            n_lbl = (forced_len != 0) ? $urandom_range(1, 3) : $urandom_range(0, 4);
            if ($urandom_range(0, 6) == 0)
                chars.push_back(CH_DOT);
            for (int l = 0; l < n_lbl; l++)
            begin
                if (l > 0)
                begin
                    chars.push_back(CH_DOT);
                    if ($urandom_range(0, 4) == 0)
                        chars.push_back(CH_DOT);
                end
                if (l == 0 && forced_len != 0)
                    len = forced_len;
                else if ($urandom_range(0, 39) == 0)
                    len = LABEL_DEPTH;
                else if ($urandom_range(0, 39) == 0)
                    len = $urandom_range(LABEL_DEPTH + 1, LABEL_DEPTH + 7);
                else
                    len = $urandom_range(1, 8);
                repeat (len)
                    chars.push_back(pick_label_char());
            end
            tail = $urandom_range(0, 3);
            if (tail == 0)
                chars.push_back(CH_DOT);
            else if (tail == 1 || chars.size() == 0)
                chars.push_back(CH_NEWLINE);
        end
        foreach (chars[i])
            send_item(chars[i], i == chars.size() - 1, 1'b0, '0);
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got = '{out_byte, is_length, run_last, name_done, error};
        if (wire_bytes_due.size() == 0)
            report_mismatch("unexpected result", got, 0);
        else
        begin
            want = wire_bytes_due.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.is_length !== want.is_length)
                report_mismatch("is_length", got.is_length, want.is_length);
            if (got.run_last !== want.run_last)
                report_mismatch("run_last", got.run_last, want.run_last);
            if (got.name_done !== want.name_done)
                report_mismatch("name_done", got.name_done, want.name_done);
            if (got.error !== want.error)
                report_mismatch("error", got.error, want.error);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            if (long_hold || stall_left > 0)
            begin
                out_ready <= 1'b0;
                if (stall_left > 0)
                    stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 5);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // The receiver holds off long enough that the block fills up and stalls its input.
    initial
    begin
        wait (items_sent >= HOLD_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dns_label_encoder test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(directed_rows[i].ch, directed_rows[i].fin,
                      directed_rows[i].typed, directed_rows[i].want);

        send_name(LABEL_DEPTH);
        send_name(LABEL_DEPTH + 3);
        while (items_sent < ITEM_TARGET)
            send_name(0);
        in_valid <= 1'b0;

        while (wire_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("dns_label_encoder test passed");
        else
            $display("dns_label_encoder test failed");
        $finish;
    end

endmodule

FILE: dns_label_encoder.f
sv/dle_pkg.sv
sv/dle_ram.sv
sv/dle_ctrl.sv
sv/dns_label_encoder.sv
sv/dle_checker.sv
test/dns_label_encoder_test.sv
